// ----- rtl/timer_slot_event_scheduler_assert.svh -----
// ----------------------------------------------------------------------------
// timer slot event scheduler assertion macros
// shared property wrappers, clocked on the rising edge, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TIMER_SLOT_EVENT_SCHEDULER_ASSERT_SVH
`define TIMER_SLOT_EVENT_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define TSES_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSES_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tses_pkg.sv -----
// ----------------------------------------------------------------------------
// tses_pkg
// opcodes, result kinds, controller states and the control/status bundles
// ----------------------------------------------------------------------------
package tses_pkg;

    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 5;
    localparam int DELTA_W = 31;
    localparam int KIND_W  = 3;
    localparam int OP_W    = 2;

    localparam logic [DELTA_W-1:0] DELTA_NONE = {DELTA_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_SCHED    = 2'd1,
        OP_POST     = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED    = 3'd0,
        KIND_NEXT     = 3'd1,
        KIND_ACCEPTED = 3'd2,
        KIND_REJECTED = 3'd3,
        KIND_EVENT    = 3'd4,
        KIND_EMPTY    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL,
        ST_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;      // capture the incoming command
        logic scan_step;   // retire the current timer slot of a tick
        logic final_emit;  // send the next-deadline result
        logic exec;        // run a schedule, post or dispatch
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic fire;        // current scan slot is due
        logic idx_last;    // current scan slot is the highest one
    } status_t;

endpackage

// ----- rtl/tses_ctrl.sv -----
// ----------------------------------------------------------------------------
// tses_ctrl
// command sequencer: accept, timer scan, final result, single-result commands
// ----------------------------------------------------------------------------
module tses_ctrl
    import tses_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [OP_W-1:0] s_opcode,
    output logic            s_ready,
    input  status_t         status,
    output cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (op_t'(s_opcode) == OP_TICK) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_SCAN: begin
                // a due slot needs room in the output register
                if (!status.fire || status.out_free) begin
                    cmd.scan_step = 1'b1;
                    if (status.idx_last) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (status.out_free) begin
                    cmd.final_emit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tses_dp.sv -----
// ----------------------------------------------------------------------------
// tses_dp
// time counter, timer table, event slot bitmap and queue, output register
// ----------------------------------------------------------------------------
module tses_dp
    import tses_pkg::*;
#(
    parameter int TIMER_SLOTS = 8,
    parameter int EVENT_SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    input  logic [OP_W-1:0]    s_opcode,
    input  logic [TIME_W-1:0]  s_delay_ticks,
    output status_t            status,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [KIND_W-1:0]  m_kind,
    output logic [SLOT_W-1:0]  m_slot,
    output logic [DELTA_W-1:0] m_next_delta,
    output logic               m_last
);

    localparam int TW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int EW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int CW = $clog2(EVENT_SLOTS + 1);
    localparam int SW = EW + 2;

    // stores
    logic [TIME_W-1:0] trig_mem [TIMER_SLOTS];
    logic [EW-1:0]     fifo_mem [EVENT_SLOTS];

    // state
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [EVENT_SLOTS-1:0] busy_reg, busy_next;
    logic [EW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [TW-1:0]          idx_reg, idx_next;
    logic [DELTA_W-1:0]     smallest_reg, smallest_next;
    op_t                    op_reg;
    logic [TIME_W-1:0]      delay_reg;
    logic [TIME_W-1:0]      trig_rdata_reg;
    logic [EW-1:0]          fifo_rdata_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg, out_kind_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [DELTA_W-1:0] out_delta_reg, out_delta_next;
    logic               out_last_reg, out_last_next;
    logic               out_load;
    logic               out_free;

    // memory ports
    logic              trig_we;
    logic [TW-1:0]     trig_waddr;
    logic              trig_rd_en;
    logic [TW-1:0]     trig_rd_addr;
    logic              fifo_we;
    logic [EW-1:0]     fifo_waddr;

    // scan and allocation helpers
    logic [TIME_W-1:0] remain;
    logic              idx_valid;
    logic              fire;
    logic              idx_last;
    logic [TW-1:0]     tfree;
    logic              tfull;
    logic [EW-1:0]     efree;
    logic              efull;
    logic [SW-1:0]     tail_sum;
    logic [EW-1:0]     tail;

    assign out_free  = !out_valid_reg || m_ready;
    assign remain    = trig_rdata_reg - time_reg;
    assign idx_valid = valid_reg[idx_reg];
    assign fire      = idx_valid && ((remain == '0) || remain[TIME_W-1]);
    assign idx_last  = (idx_reg == TW'(TIMER_SLOTS - 1));

    assign status.out_free = out_free;
    assign status.fire     = fire;
    assign status.idx_last = idx_last;

    // lowest free slots
    always_comb begin
        tfree = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                tfree = TW'(i);
            end
        end
        efree = '0;
        for (int j = EVENT_SLOTS - 1; j >= 0; j--) begin
            if (!busy_reg[j]) begin
                efree = EW'(j);
            end
        end
    end

    assign tfull = &valid_reg;
    assign efull = (&busy_reg) || (count_reg >= CW'(EVENT_SLOTS));

    // queue tail, wrapped once since pointer plus count stays below twice the depth
    always_comb begin
        tail_sum = SW'(rd_ptr_reg) + SW'(count_reg);
        if (tail_sum >= SW'(EVENT_SLOTS)) begin
            tail_sum = tail_sum - SW'(EVENT_SLOTS);
        end
        tail = tail_sum[EW-1:0];
    end

    always_comb begin
        time_next      = time_reg;
        valid_next     = valid_reg;
        busy_next      = busy_reg;
        rd_ptr_next    = rd_ptr_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        smallest_next  = smallest_reg;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_slot_next  = out_slot_reg;
        out_delta_next = out_delta_reg;
        out_last_next  = out_last_reg;
        trig_we        = 1'b0;
        trig_waddr     = tfree;
        trig_rd_en     = 1'b0;
        trig_rd_addr   = '0;
        fifo_we        = 1'b0;
        fifo_waddr     = tail;

        if (cmd.accept && (op_t'(s_opcode) == OP_TICK)) begin
            time_next     = time_reg + TIME_W'(1);
            idx_next      = '0;
            smallest_next = DELTA_NONE;
            trig_rd_en    = 1'b1;
        end

        if (cmd.scan_step) begin
            if (fire) begin
                valid_next[idx_reg] = 1'b0;
                out_load            = 1'b1;
                out_kind_next       = KIND_FIRED;
                out_slot_next       = SLOT_W'(idx_reg);
                out_delta_next      = '0;
                out_last_next       = 1'b0;
            end else if (idx_valid && (remain[DELTA_W-1:0] < smallest_reg)) begin
                smallest_next = remain[DELTA_W-1:0];
            end
            if (!idx_last) begin
                idx_next     = idx_reg + TW'(1);
                trig_rd_en   = 1'b1;
                trig_rd_addr = idx_reg + TW'(1);
            end
        end

        if (cmd.final_emit) begin
            out_load       = 1'b1;
            out_kind_next  = KIND_NEXT;
            out_slot_next  = '0;
            out_delta_next = smallest_reg;
            out_last_next  = 1'b1;
        end

        if (cmd.exec) begin
            out_load       = 1'b1;
            out_slot_next  = '0;
            out_delta_next = '0;
            out_last_next  = 1'b1;
            out_kind_next  = KIND_REJECTED;
            case (op_reg)
                OP_SCHED: begin
                    if (!delay_reg[TIME_W-1] && !tfull) begin
                        trig_we           = 1'b1;
                        valid_next[tfree] = 1'b1;
                        out_kind_next     = KIND_ACCEPTED;
                        out_slot_next     = SLOT_W'(tfree);
                    end
                end
                OP_POST: begin
                    if (!efull) begin
                        fifo_we          = 1'b1;
                        busy_next[efree] = 1'b1;
                        count_next       = count_reg + CW'(1);
                        out_kind_next    = KIND_ACCEPTED;
                        out_slot_next    = SLOT_W'(efree);
                    end
                end
                OP_DISPATCH: begin
                    if (count_reg == '0) begin
                        out_kind_next = KIND_EMPTY;
                    end else begin
                        busy_next[fifo_rdata_reg] = 1'b0;
                        count_next                = count_reg - CW'(1);
                        if (rd_ptr_reg == EW'(EVENT_SLOTS - 1)) begin
                            rd_ptr_next = '0;
                        end else begin
                            rd_ptr_next = rd_ptr_reg + EW'(1);
                        end
                        out_kind_next = KIND_EVENT;
                        out_slot_next = SLOT_W'(fifo_rdata_reg);
                    end
                end
                default: begin
                    out_load = 1'b0;
                end
            endcase
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg      <= '0;
            valid_reg     <= '0;
            busy_reg      <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            time_reg      <= time_next;
            valid_reg     <= valid_next;
            busy_reg      <= busy_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        smallest_reg  <= smallest_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_delta_reg <= out_delta_next;
        out_last_reg  <= out_last_next;
        if (cmd.accept) begin
            op_reg    <= op_t'(s_opcode);
            delay_reg <= s_delay_ticks;
        end
    end

    // trigger time table, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (trig_we) begin
            trig_mem[trig_waddr] <= time_reg + delay_reg;
        end
        if (trig_rd_en) begin
            trig_rdata_reg <= trig_mem[trig_rd_addr];
        end
    end

    // event queue, head read every cycle
    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[fifo_waddr] <= efree;
        end
        fifo_rdata_reg <= fifo_mem[rd_ptr_reg];
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_slot       = out_slot_reg;
    assign m_next_delta = out_delta_reg;
    assign m_last       = out_last_reg;

endmodule

// ----- rtl/timer_slot_event_scheduler.sv -----
// ----------------------------------------------------------------------------
// timer_slot_event_scheduler
// multi-slot one-shot timer table with a bitmap-allocated event queue
// ----------------------------------------------------------------------------
// Commands arrive one per transfer on the s_ channel and are worked one at a
// time. A tick (opcode 0) bumps the 32-bit tick counter, then walks the timer
// slots in index order at one slot per cycle (a due slot stalls the walk while
// the output register is full) through the single read port of the
// trigger-time table; every due slot is freed and reported as a "timer fired"
// transfer, and the walk ends with one "next deadline" transfer giving the
// smallest remaining distance (all ones when nothing is pending), marked with
// m_last. Schedule, post and dispatch (opcodes 1 to 3) each give exactly one
// result with m_last set. Back-pressure on m_ready holds the command back
// whenever a new result is ready to load while the previous one still waits in
// the output register. A delay with bit 31 set, a full timer table or a full
// event table is answered with "rejected"; dispatching from an empty queue
// answers "queue empty". No clearing pass runs after reset: free slots are
// tracked by bitmaps, so table contents are only read once written.
// ----------------------------------------------------------------------------
`include "timer_slot_event_scheduler_assert.svh"

module timer_slot_event_scheduler
    import tses_pkg::*;
#(
    parameter int TIMER_SLOTS = 8,
    parameter int EVENT_SLOTS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // command channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_opcode,
    input  logic [TIME_W-1:0]  s_delay_ticks,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_kind,
    output logic [SLOT_W-1:0]  m_slot,
    output logic [DELTA_W-1:0] m_next_delta,
    output logic               m_last
);

    cmd_t    cmd;
    status_t status;

    // sequencer: decides when each command step may run
    tses_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // tables, queue, tick counter and the output register
    tses_dp #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .EVENT_SLOTS (EVENT_SLOTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_opcode      (s_opcode),
        .s_delay_ticks (s_delay_ticks),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_kind        (m_kind),
        .m_slot        (m_slot),
        .m_next_delta  (m_next_delta),
        .m_last        (m_last)
    );

    // one command in flight: a transfer closes the command port
    `TSES_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "command accepted while busy")

    // the end of a tick walk always lands as a final deadline result
    `TSES_ASSERT_NEXT(a_final_result, aclk, aresetn, cmd.final_emit, m_valid && m_last && (m_kind == KIND_NEXT), "tick did not close with a deadline result")

    // a fired timer is never the last result of its tick
    `TSES_ASSERT_NOW(a_fired_not_last, aclk, aresetn, m_valid && (m_kind == KIND_FIRED), !m_last, "fired timer flagged as last")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer slot event scheduler testbench
// drives tick, schedule, post and dispatch commands into the scheduler, keeps
// its own copy of the timer table and event queue, and checks every result
// transfer against the predicted sequence, with random idling on both sides
// ----------------------------------------------------------------------------
module testbench;
    import tses_pkg::*;

    localparam int TIMER_SLOTS = 8;
    localparam int EVENT_SLOTS = 8;
    localparam int RESET_CYCLES = 10;
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall to back up the block
    localparam int SETTLE_CYCLES = 30;
    localparam int unsigned CYCLE_LIMIT = 300000;

    // one result transfer, field for field
    typedef struct packed {
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic [DELTA_W-1:0] delta;
        logic               last;
    } sched_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirrors the timer table and the event queue, holds the
    // results still to come in the order the block must send them
    // ------------------------------------------------------------------------
    class scheduler_scoreboard;
        logic [TIME_W-1:0]      tick_now;
        logic [TIMER_SLOTS-1:0] timer_armed;
        logic [TIME_W-1:0]      deadline [TIMER_SLOTS];
        logic [EVENT_SLOTS-1:0] event_taken;
        logic [SLOT_W-1:0]      event_order [EVENT_SLOTS];
        int unsigned            order_head;
        int unsigned            order_count;
        sched_result_t          awaited_results [$];
        int unsigned            errors;

        function new();
            tick_now    = '0;
            timer_armed = '0;
            event_taken = '0;
            order_head  = 0;
            order_count = 0;
            errors      = 0;
        endfunction

        // lowest free slot, or width when every slot is taken
        function int lowest_clear(logic [31:0] map, int width);
            for (int i = 0; i < width; i++) begin
                if (!map[i]) return i;
            end
            return width;
        endfunction

        function void queue_result(kind_t kind, int slot, logic [DELTA_W-1:0] delta,
                                   logic last);
            sched_result_t r;
            r.kind  = kind;
            r.slot  = SLOT_W'(slot);
            r.delta = delta;
            r.last  = last;
            awaited_results.push_back(r);
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // accepted command: advance the mirror and queue what it causes
        function void note_command(op_t op, logic [TIME_W-1:0] delay);
            logic [TIME_W-1:0] remain;
            logic [TIME_W-1:0] nearest;
            int                s;
            case (op)
                OP_TICK: begin
                    tick_now = tick_now + 1;
                    nearest  = {1'b0, DELTA_NONE};
                    for (int i = 0; i < TIMER_SLOTS; i++) begin
                        if (timer_armed[i]) begin
                            // wrap-aware: due when the signed distance is not positive
                            remain = deadline[i] - tick_now;
                            if (remain == '0 || remain[TIME_W-1]) begin
                                timer_armed[i] = 1'b0;
                                queue_result(KIND_FIRED, i, '0, 1'b0);
                            end else if (remain < nearest) begin
                                nearest = remain;
                            end
                        end
                    end
                    queue_result(KIND_NEXT, 0, nearest[DELTA_W-1:0], 1'b1);
                end
                OP_SCHED: begin
                    s = lowest_clear(32'(timer_armed), TIMER_SLOTS);
                    if (delay[TIME_W-1] || s >= TIMER_SLOTS) begin
                        queue_result(KIND_REJECTED, 0, '0, 1'b1);
                    end else begin
                        deadline[s]    = tick_now + delay;
                        timer_armed[s] = 1'b1;
                        queue_result(KIND_ACCEPTED, s, '0, 1'b1);
                    end
                end
                OP_POST: begin
                    s = lowest_clear(32'(event_taken), EVENT_SLOTS);
                    if (s >= EVENT_SLOTS) begin
                        queue_result(KIND_REJECTED, 0, '0, 1'b1);
                    end else begin
                        event_taken[s] = 1'b1;
                        event_order[(order_head + order_count) % EVENT_SLOTS] = SLOT_W'(s);
                        order_count++;
                        queue_result(KIND_ACCEPTED, s, '0, 1'b1);
                    end
                end
                OP_DISPATCH: begin
                    if (order_count == 0) begin
                        queue_result(KIND_EMPTY, 0, '0, 1'b1);
                    end else begin
                        s = event_order[order_head];
                        order_head = (order_head + 1) % EVENT_SLOTS;
                        order_count--;
                        event_taken[s] = 1'b0;
                        queue_result(KIND_EVENT, s, '0, 1'b1);
                    end
                end
            endcase
        endfunction

        // accepted result: compare with the oldest expectation
        function void check_result(sched_result_t got);
            sched_result_t want;
            if (awaited_results.size() == 0) begin
                errors++;
                $display("%0t ns: result with nothing expected, actual kind=%0d slot=%0d next_delta=%0d last=%0d",
                         $time, got.kind, got.slot, got.delta, got.last);
                return;
            end
            want = awaited_results.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t ns: result mismatch, expected kind=%0d slot=%0d next_delta=%0d last=%0d, actual kind=%0d slot=%0d next_delta=%0d last=%0d",
                         $time, want.kind, want.slot, want.delta, want.last,
                         got.kind, got.slot, got.delta, got.last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [OP_W-1:0]    s_opcode;
    logic [TIME_W-1:0]  s_delay_ticks;
    logic               m_valid;
    logic               m_ready;
    logic [KIND_W-1:0]  m_kind;
    logic [SLOT_W-1:0]  m_slot;
    logic [DELTA_W-1:0] m_next_delta;
    logic               m_last;

    timer_slot_event_scheduler #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .EVENT_SLOTS (EVENT_SLOTS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_delay_ticks (s_delay_ticks),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_slot        (m_slot),
        .m_next_delta  (m_next_delta),
        .m_last        (m_last)
    );

    scheduler_scoreboard sb;
    sched_result_t       seen_result;
    bit                  quiet_phase;   // no idling on either side while set
    bit                  hold_req;      // asks the receiver for one long stall
    int unsigned         hold_left;
    int unsigned         cycle_count;

    // 20 ns clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit, generous against the slowest legal run
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, none in the quiet phase, and one long hold-off
    // counted here so the sender keeps offering while the block fills up
    initial hold_left = 0;
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else if (quiet_phase) begin
            m_ready = 1'b1;
        end else begin
            m_ready = ($urandom_range(0, 99) >= 17);
        end
    end

    // monitor: both channels sampled at the rising edge; the result is checked
    // before the command of the same edge is noted, it cannot stem from it
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_result.kind  = kind_t'(m_kind);
                seen_result.slot  = m_slot;
                seen_result.delta = m_next_delta;
                seen_result.last  = m_last;
                sb.check_result(seen_result);
            end
            if (s_valid && s_ready) begin
                sb.note_command(op_t'(s_opcode), s_delay_ticks);
            end
        end
    end

    // one command transfer; called and returning at a falling edge, valid is
    // left high so a following command keeps it up unless it idles first
    task automatic send_command(input op_t op, input logic [TIME_W-1:0] delay);
        if (!quiet_phase && $urandom_range(0, 99) < 17) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_opcode      = op;
        s_delay_ticks = delay;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // sender pause until the block has answered everything
    task automatic wait_all_results();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // mostly schedules with short delays and ticks so timers really fire,
    // with posts and dispatches churning the event queue
    task automatic run_random(input int unsigned count);
        int unsigned       pick;
        int unsigned       span;
        op_t               op;
        logic [TIME_W-1:0] delay;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = OP_TICK;
            else if (pick < 65) op = OP_SCHED;
            else if (pick < 82) op = OP_POST;
            else                op = OP_DISPATCH;
            span = $urandom_range(0, 99);
            if (span < 60)      delay = $urandom_range(0, 12);
            else if (span < 75) delay = $urandom_range(13, 300);
            else if (span < 90) delay = $urandom;
            else                delay = 32'h7FFF_FFF8 + $urandom_range(0, 15);   // around bit 31
            send_command(op, delay);
        end
    endtask

    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_opcode      = OP_TICK;
        s_delay_ticks = '0;
        m_ready       = 1'b0;
        quiet_phase   = 1'b0;
        hold_req      = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: empty tables, delay extremes, full tables, bulk firing
        send_command(OP_TICK, '0);                  // nothing pending
        send_command(OP_DISPATCH, '0);              // empty queue
        send_command(OP_SCHED, '0);                 // zero delay, due next tick
        send_command(OP_SCHED, 32'h7FFF_FFFF);      // largest legal delay
        send_command(OP_SCHED, 32'h8000_0000);      // bit 31 set, rejected
        send_command(OP_SCHED, 32'hFFFF_FFFF);      // rejected too
        send_command(OP_TICK, '0);                  // zero-delay timer fires
        repeat (TIMER_SLOTS - 1) send_command(OP_SCHED, 32'd1);
        send_command(OP_SCHED, 32'd5);              // timer table full
        send_command(OP_TICK, '0);                  // every short timer fires
        repeat (EVENT_SLOTS) send_command(OP_POST, $urandom);
        send_command(OP_POST, $urandom);            // event table full
        send_command(OP_DISPATCH, $urandom);
        wait_all_results();

        // random with idling on both sides
        run_random(150);
        wait_all_results();

        // long stretch with no idling at all
        quiet_phase = 1'b1;
        run_random(100);
        wait_all_results();
        quiet_phase = 1'b0;

        // receiver holds off while commands keep coming
        hold_req = 1'b1;
        run_random(40);
        wait_all_results();

        run_random(110);
        wait_all_results();

        // let any stray transfer show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
